// File: hdl/sorted_key_table_lookup_insert_macros.svh
// assertion macros for the sorted key table
`ifndef SORTED_KEY_TABLE_LOOKUP_INSERT_MACROS_SVH
`define SORTED_KEY_TABLE_LOOKUP_INSERT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SKT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define SKT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/skt_pkg.sv
// shared constants, result codes and control structs of the sorted key table
package skt_pkg;

  localparam int unsigned CAPACITY_DEF    = 1024;
  localparam int unsigned PAGE_BITS_DEF   = 32;
  localparam int unsigned BUFFER_BITS_DEF = 8;

  localparam int unsigned IN_PAGE_W   = 32;
  localparam int unsigned IN_BUF_W    = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned POS_W       = 11;
  localparam int unsigned REF_W       = 10;
  localparam int unsigned S_TDATA_W   = 40;
  localparam int unsigned M_TDATA_W   = 24;
  localparam int unsigned M_TDATA_PAD = M_TDATA_W - POS_W - REF_W;

  localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  localparam logic KIND_LOOKUP = 1'b0;

  typedef struct packed {
    logic load;
    logic search_rd;
    logic compare;
    logic shift_start;
    logic shift_step;
    logic insert;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic range_open;
    logic hit;
    logic kind;
    logic full;
    logic shift_needed;
    logic shift_more;
  } dp_sts_t;

endpackage

// File: hdl/skt_ctrl.sv
// request sequencer: search, resolve, shift and insert, result hand-off
module skt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  skt_pkg::dp_sts_t sts_i,
  output skt_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SEARCH  = 3'd1;
  localparam logic [2:0] ST_COMPARE = 3'd2;
  localparam logic [2:0] ST_RESOLVE = 3'd3;
  localparam logic [2:0] ST_SHIFT   = 3'd4;
  localparam logic [2:0] ST_WRITE   = 3'd5;

  logic [2:0] state_d, state_q;
  logic       out_valid_d, out_valid_q;
  logic       slot_free;

  assign slot_free = !out_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts_i.range_open) begin
          cmd_o.search_rd = 1'b1;
          state_d         = ST_COMPARE;
        end else begin
          state_d = ST_RESOLVE;
        end
      end
      ST_COMPARE: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_SEARCH;
      end
      ST_RESOLVE: begin
        if (sts_i.hit || (sts_i.kind == skt_pkg::KIND_LOOKUP) || sts_i.full) begin
          if (slot_free) begin
            cmd_o.publish = 1'b1;
            state_d       = ST_IDLE;
          end
        end else if (sts_i.shift_needed) begin
          cmd_o.shift_start = 1'b1;
          state_d           = ST_SHIFT;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (!sts_i.shift_more) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (slot_free) begin
          cmd_o.insert  = 1'b1;
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/skt_dp.sv
// table memory, search bounds, shift pointer, counters and result registers
`include "sorted_key_table_lookup_insert_macros.svh"

module skt_dp #(
  parameter int unsigned CAPACITY    = skt_pkg::CAPACITY_DEF,
  parameter int unsigned PAGE_BITS   = skt_pkg::PAGE_BITS_DEF,
  parameter int unsigned BUFFER_BITS = skt_pkg::BUFFER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          kind_i,
  input  logic [skt_pkg::IN_PAGE_W-1:0] page_number_i,
  input  logic [skt_pkg::IN_BUF_W-1:0]  buffer_index_i,
  input  skt_pkg::dp_cmd_t              cmd_i,
  output skt_pkg::dp_sts_t              sts_o,
  output logic [skt_pkg::STATUS_W-1:0]  status_o,
  output logic [skt_pkg::POS_W-1:0]     position_o,
  output logic [skt_pkg::REF_W-1:0]     page_ref_o
);

  localparam int unsigned AW     = $clog2(CAPACITY);
  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned REF_W  = skt_pkg::REF_W;
  localparam int unsigned WORD_W = PAGE_BITS + BUFFER_BITS + REF_W;

  logic [WORD_W-1:0] mem_q [CAPACITY];
  logic [WORD_W-1:0] rd_data_q;
  logic [WORD_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              rd_en, wr_en;

  logic [PAGE_BITS-1:0]   key_page_q;
  logic [BUFFER_BITS-1:0] key_buf_q;
  logic                   kind_q;

  logic [CW-1:0]    count_q, lo_q, hi_q, mid_q, sh_q;
  logic [CW-1:0]    mid, count_m1, sh_m2, pos_res;
  logic [REF_W-1:0] next_ref_q, hit_ref_q, ref_res;
  logic             hit_q, full;
  logic [skt_pkg::STATUS_W-1:0] status_res;

  logic [PAGE_BITS-1:0]   rd_page;
  logic [BUFFER_BITS-1:0] rd_buf;
  logic [REF_W-1:0]       rd_ref;
  logic                   key_ge, key_eq;

  assign rd_page = rd_data_q[PAGE_BITS-1:0];
  assign rd_buf  = rd_data_q[PAGE_BITS +: BUFFER_BITS];
  assign rd_ref  = rd_data_q[PAGE_BITS+BUFFER_BITS +: REF_W];

  assign key_eq = (key_page_q == rd_page) && (key_buf_q == rd_buf);
  assign key_ge = (key_page_q > rd_page) || ((key_page_q == rd_page) && (key_buf_q >= rd_buf));

  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign count_m1 = count_q - CW'(1);
  assign sh_m2    = sh_q - CW'(2);
  assign full     = (count_q == CW'(CAPACITY));

  assign sts_o.range_open   = (lo_q < hi_q);
  assign sts_o.hit          = hit_q;
  assign sts_o.kind         = kind_q;
  assign sts_o.full         = full;
  assign sts_o.shift_needed = (count_q > lo_q);
  assign sts_o.shift_more   = (sh_q > (lo_q + CW'(1)));

  // memory port steering
  always_comb begin
    rd_en   = cmd_i.search_rd || cmd_i.shift_start || (cmd_i.shift_step && sts_o.shift_more);
    rd_addr = sh_m2[AW-1:0];
    if (cmd_i.search_rd) begin
      rd_addr = mid[AW-1:0];
    end else if (cmd_i.shift_start) begin
      rd_addr = count_m1[AW-1:0];
    end
    wr_en   = cmd_i.shift_step || cmd_i.insert;
    wr_addr = sh_q[AW-1:0];
    wr_data = rd_data_q;
    if (cmd_i.insert) begin
      wr_addr = lo_q[AW-1:0];
      wr_data = {next_ref_q, key_buf_q, key_page_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // outcome of the finished request
  always_comb begin
    pos_res    = hit_q ? (lo_q - CW'(1)) : lo_q;
    ref_res    = '0;
    status_res = skt_pkg::STATUS_INSERTED;
    if (hit_q) begin
      status_res = skt_pkg::STATUS_FOUND;
      ref_res    = hit_ref_q;
    end else if (kind_q == skt_pkg::KIND_LOOKUP) begin
      status_res = skt_pkg::STATUS_MISSING;
    end else if (full) begin
      status_res = skt_pkg::STATUS_FULL;
    end else begin
      ref_res = next_ref_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      next_ref_q <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      hit_q      <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        lo_q  <= '0;
        hi_q  <= count_q;
        hit_q <= 1'b0;
      end
      if (cmd_i.compare) begin
        if (key_ge) begin
          lo_q <= mid_q + CW'(1);
          if (key_eq) begin
            hit_q <= 1'b1;
          end
        end else begin
          hi_q <= mid_q;
        end
      end
      if (cmd_i.insert) begin
        count_q    <= count_q + CW'(1);
        next_ref_q <= next_ref_q + REF_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_page_q <= PAGE_BITS'(page_number_i);
      key_buf_q  <= BUFFER_BITS'(buffer_index_i);
      kind_q     <= kind_i;
    end
    if (cmd_i.search_rd) begin
      mid_q <= mid;
    end
    if (cmd_i.compare && key_eq) begin
      hit_ref_q <= rd_ref;
    end
    if (cmd_i.shift_start) begin
      sh_q <= count_q;
    end else if (cmd_i.shift_step) begin
      sh_q <= sh_q - CW'(1);
    end
    if (cmd_i.publish) begin
      status_o   <= status_res;
      position_o <= skt_pkg::POS_W'(pos_res);
      page_ref_o <= ref_res;
    end
  end

  `SKT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "entry count beyond capacity")
  `SKT_ASSERT_NOW(a_bounds_order, 1'b1, lo_q <= hi_q, "search bounds crossed")
  `SKT_ASSERT_NOW(a_insert_room, cmd_i.insert, !full && !hit_q, "insert into full table or on hit")
  `SKT_ASSERT_NOW(a_shift_above, cmd_i.shift_step, sh_q > lo_q, "shift writes at or below insertion point")
  `SKT_ASSERT_NEXT(a_count_step, cmd_i.insert, count_q == $past(count_q) + CW'(1), "count not advanced by insert")

endmodule

// File: hdl/sorted_key_table_lookup_insert.sv
// top level of the sorted key table with binary-search lookup and ordered insert
//
//  channel  dir  handshake              tuser                 tdata (lowest bit up)
//  s_axis   in   tvalid/tready          kind                  page_number, buffer_index
//  m_axis   out  tvalid/tready          status                position, page_ref, zero pad
//
//  one request at a time; a search probe is a memory read, then a compare
//  an insert moves each entry above the insertion point up one place, then writes the key
//  one registered read and one write of the table memory per cycle bound probe and shift rate
//  a finished result waits in the output register; the next request is taken meanwhile
//  no clearing pass after reset: the entry count marks the valid part of the table
module sorted_key_table_lookup_insert #(
  parameter int unsigned CAPACITY    = skt_pkg::CAPACITY_DEF,
  parameter int unsigned PAGE_BITS   = skt_pkg::PAGE_BITS_DEF,
  parameter int unsigned BUFFER_BITS = skt_pkg::BUFFER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [skt_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // page_number, buffer_index
  input  logic                          s_axis_tuser_i,  // kind
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [skt_pkg::M_TDATA_W-1:0] m_axis_tdata_o,  // position, page_ref, zero pad
  output logic [skt_pkg::STATUS_W-1:0]  m_axis_tuser_o   // status
);

  skt_pkg::dp_cmd_t cmd;
  skt_pkg::dp_sts_t sts;

  logic [skt_pkg::POS_W-1:0] position;
  logic [skt_pkg::REF_W-1:0] page_ref;

  skt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  skt_dp #(
    .CAPACITY    (CAPACITY),
    .PAGE_BITS   (PAGE_BITS),
    .BUFFER_BITS (BUFFER_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (s_axis_tuser_i),
    .page_number_i  (s_axis_tdata_i[skt_pkg::IN_PAGE_W-1:0]),
    .buffer_index_i (s_axis_tdata_i[skt_pkg::IN_PAGE_W +: skt_pkg::IN_BUF_W]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (m_axis_tuser_o),
    .position_o     (position),
    .page_ref_o     (page_ref)
  );

  assign m_axis_tdata_o = {{skt_pkg::M_TDATA_PAD{1'b0}}, page_ref, position};

endmodule

// File: tb/sorted_key_table_monitor.sv
// channel monitor: predicts each lookup or insert and checks the returned results
module sorted_key_table_monitor #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [skt_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic                          s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [skt_pkg::M_TDATA_W-1:0] m_tdata_i,
  input  logic [skt_pkg::STATUS_W-1:0]  m_tuser_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_W = skt_pkg::IN_PAGE_W + skt_pkg::IN_BUF_W;

  typedef struct packed {
    logic [skt_pkg::STATUS_W-1:0] status;
    logic [skt_pkg::POS_W-1:0]    position;
    logic [skt_pkg::REF_W-1:0]    page_ref;
  } lookup_result_t;

  // key is page number above buffer index, so one unsigned compare gives the table order
  logic [KEY_W-1:0]          key_store [CAPACITY];
  logic [skt_pkg::REF_W-1:0] ref_store [CAPACITY];
  int unsigned               stored;
  logic [skt_pkg::REF_W-1:0] next_ref;
  lookup_result_t            awaited_q [$];
  int                        errors = 0;

  assign fail_count_o = errors;

  function automatic lookup_result_t search_and_insert(
    input logic             kind,
    input logic [KEY_W-1:0] key
  );
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    int unsigned    i;
    lookup_result_t res;
    lo = 0;
    hi = stored;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (key_store[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    res.position = skt_pkg::POS_W'(lo);
    res.page_ref = '0;
    if (lo < stored && key_store[lo] == key) begin
      res.status   = skt_pkg::STATUS_FOUND;
      res.page_ref = ref_store[lo];
    end else if (kind == skt_pkg::KIND_LOOKUP) begin
      res.status = skt_pkg::STATUS_MISSING;
    end else if (stored >= CAPACITY) begin
      res.status = skt_pkg::STATUS_FULL;
    end else begin
      for (i = stored; i > lo; i--) begin
        key_store[i] = key_store[i-1];
        ref_store[i] = ref_store[i-1];
      end
      key_store[lo] = key;
      ref_store[lo] = next_ref;
      res.page_ref  = next_ref;
      res.status    = skt_pkg::STATUS_INSERTED;
      next_ref++;
      stored++;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lookup_result_t want;
    lookup_result_t got;
    if (!rst_ni) begin
      stored   = 0;
      next_ref = '0;
      awaited_q.delete();
      pending_o <= 0;
    end else begin
      // results first: a result never belongs to the request taken at the same edge
      if (m_tvalid_i && m_tready_i) begin
        got = '{m_tuser_i, m_tdata_i[skt_pkg::POS_W-1:0],
                m_tdata_i[skt_pkg::POS_W+skt_pkg::REF_W-1:skt_pkg::POS_W]};
        if (awaited_q.size() == 0) begin
          errors++;
          $error("unexpected result: status %0d position %0d page_ref %0d",
                 got.status, got.position, got.page_ref);
        end else begin
          want = awaited_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("position", want.position, got.position);
          check_field("page_ref", want.page_ref, got.page_ref);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        awaited_q.push_back(search_and_insert(
          s_tuser_i, {s_tdata_i[skt_pkg::IN_PAGE_W-1:0], s_tdata_i[KEY_W-1:skt_pkg::IN_PAGE_W]}));
      end
      pending_o <= awaited_q.size();
    end
  end

endmodule

// File: tb/sorted_key_table_lookup_insert_tb.sv
// testbench top: clock, reset, request stimulus, result back-pressure and verdict
module sorted_key_table_lookup_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // reduced depth so the full table is reached within the run
  localparam int unsigned TABLE_CAP    = 256;
  localparam logic        KIND_LOAD    = skt_pkg::KIND_LOOKUP;
  localparam logic        KIND_SAVE    = ~skt_pkg::KIND_LOOKUP;
  localparam int          RANDOM_ITEMS = 570;
  localparam int          HOLD_AT      = 150;
  localparam int          PAUSE_AT     = 320;
  localparam int          LONG_HOLD    = 3000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned S_W          = skt_pkg::S_TDATA_W;

  logic                          clk_i     = 1'b0;
  logic                          rst_ni    = 1'b0;
  logic                          s_tvalid  = 1'b0;
  logic [S_W-1:0]                s_tdata   = '0;
  logic                          s_tuser   = 1'b0;
  logic                          m_tready  = 1'b0;
  logic                          s_tready;
  logic                          m_tvalid;
  logic [skt_pkg::M_TDATA_W-1:0] m_tdata;
  logic [skt_pkg::STATUS_W-1:0]  m_tuser;
  int                            pending;
  int                            fail_count;

  logic [S_W-1:0] saved_keys [$];
  int             burst_left  = 0;
  bit             rx_hold_req = 1'b0;
  int             cycles      = 0;

  sorted_key_table_lookup_insert #(
    .CAPACITY(TABLE_CAP)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  sorted_key_table_monitor #(
    .CAPACITY(TABLE_CAP)
  ) monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sorted_key_table_lookup_insert_tb: done, errors");
      $finish;
    end
  end

  // tdata is {buffer_index, page_number}
  task automatic offer(input logic kind, input logic [S_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tuser  <= kind;
    if (kind == KIND_SAVE) saved_keys.push_back(key);
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
  endtask

  task automatic await_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [S_W-1:0] fresh_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return {8'($urandom), 32'($urandom_range(0, 15))};
    if (r < 75) return {8'($urandom), 32'($urandom)};
    case ($urandom_range(0, 3))
      0:       return {($urandom_range(0, 1) ? 8'hFF : 8'h00), 32'h0000_0000};
      1:       return {($urandom_range(0, 1) ? 8'hFF : 8'h00), 32'hFFFF_FFFF};
      2:       return {($urandom_range(0, 1) ? 8'hFF : 8'h00), 32'h8000_0000};
      default: return {($urandom_range(0, 1) ? 8'hFF : 8'h00), 32'h7FFF_FFFF};
    endcase
  endfunction

  function automatic logic [S_W-1:0] known_key();
    return saved_keys[$urandom_range(0, saved_keys.size() - 1)];
  endfunction

  // receiver: random stall modes, plus one long hold-off on request
  initial begin
    int rx_mode;
    int rx_span;
    rx_mode = 0;
    rx_span = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_span = $urandom_range(8, 80);
      end
      rx_span--;
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
      @(posedge clk_i);
    end
  end

  initial begin
    int          n;
    int unsigned r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, key extremes, buffer index as tie-break, msb of the page number
    offer(KIND_LOAD, {8'h00, 32'h0000_0000});
    offer(KIND_SAVE, {8'h00, 32'h0000_0000});
    offer(KIND_SAVE, {8'hFF, 32'hFFFF_FFFF});
    offer(KIND_SAVE, {8'h00, 32'hFFFF_FFFF});
    offer(KIND_SAVE, {8'hFF, 32'h0000_0000});
    offer(KIND_SAVE, {8'h80, 32'h8000_0000});
    offer(KIND_SAVE, {8'h7F, 32'h7FFF_FFFF});
    offer(KIND_SAVE, {8'h80, 32'h7FFF_FFFF});
    offer(KIND_LOAD, {8'h00, 32'h0000_0000});
    offer(KIND_LOAD, {8'hFF, 32'hFFFF_FFFF});
    offer(KIND_SAVE, {8'h80, 32'h8000_0000});
    offer(KIND_LOAD, {8'h7F, 32'h8000_0000});
    offer(KIND_LOAD, {8'hFE, 32'hFFFF_FFFF});
    offer(KIND_LOAD, {8'h01, 32'h0000_0000});
    offer(KIND_SAVE, {8'h01, 32'h0000_0001});
    offer(KIND_LOAD, {8'hAA, 32'h1234_5678});
    offer(KIND_LOAD, {8'h01, 32'h0000_0001});

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) rx_hold_req = 1'b1;
      if (n == PAUSE_AT) await_results();
      r = $urandom_range(0, 99);
      if (r < 55)      offer(KIND_SAVE, fresh_key());
      else if (r < 65) offer(KIND_SAVE, known_key());
      else if (r < 90) offer(KIND_LOAD, known_key());
      else             offer(KIND_LOAD, fresh_key());
    end

    await_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sorted_key_table_lookup_insert_tb: done, clean");
    end else begin
      $display("sorted_key_table_lookup_insert_tb: done, errors");
    end
    $finish;
  end

endmodule
